/* sv/ring_buffer_deque_checker_macros.svh */
// Assertion helpers for the deque checker. The clock is clk and the reset is rst
// in every module that uses these macros.
`ifndef RING_BUFFER_DEQUE_CHECKER_MACROS_SVH
`define RING_BUFFER_DEQUE_CHECKER_MACROS_SVH
`ifndef SYNTHESIS
`define RBDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RBDQ_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define RBDQ_ASSERT(lbl, prop, msg)
`define RBDQ_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

/* sv/rbdq_pkg.sv */
`default_nettype none
package rbdq_pkg;

  localparam int unsigned DEPTH      = 1024;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_POP_FRONT  = 2'd1,
    CMD_PUSH_BACK  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_HOLD = 2'd2
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;
    logic load_out;
  } ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } stat_t;

  // Advance an index around the ring
  function automatic idx_t idx_inc(input idx_t i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
  endfunction

  // Step an index back around the ring
  function automatic idx_t idx_dec(input idx_t i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
  endfunction

endpackage
`default_nettype wire

/* sv/ring_buffer_deque_checker.sv */
// Double-ended queue checker on a fixed circular store.
// Input channel (in_valid / in_stall): command (push front, pop front, push back,
// pop back) and item_value. A push stores the value; a pop removes the element at
// that end and compares it with item_value. A pop on an empty deque matches only
// when item_value is all ones; a push on a full deque is dropped.
// Output channel (out_valid / out_stall): one result per request: popped_value,
// matched, status and the sticky all_matched flag.
// An accepted request is registered together with the store read data; its result
// then enters the output register once that register is free. The single store
// port serves one request at a time: no new request is accepted until the previous
// result has been loaded into the output register.
// A new request is accepted while the previous result still waits in the output
// register. If the receiver stalls, the next result holds inside and the input
// stalls until the output register frees. Reset empties the deque and sets the
// flag behind all_matched; store contents are not cleared.
`default_nettype none
module ring_buffer_deque_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic signed [31:0] item_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] popped_value,
  output logic               matched,
  output logic [1:0]         status,
  output logic               all_matched
);

  rbdq_pkg::ctrl_t ctrl;
  rbdq_pkg::stat_t stat;

  rbdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  rbdq_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .stat         (stat),
    .command      (command),
    .item_value   (item_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .popped_value (popped_value),
    .matched      (matched),
    .status       (status),
    .all_matched  (all_matched)
  );

endmodule
`default_nettype wire

/* sv/rbdq_ctrl.sv */
`default_nettype none
module rbdq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rbdq_pkg::stat_t    stat,
  output rbdq_pkg::ctrl_t    ctrl
);

  rbdq_pkg::state_t state;
  rbdq_pkg::state_t state_next;

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rbdq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance: take a request, wait for the store read, then hand off when the output frees
  always_comb begin
    state_next = state;
    case (state)
      rbdq_pkg::ST_IDLE: begin
        if (in_valid) state_next = rbdq_pkg::ST_READ;
      end
      rbdq_pkg::ST_READ,
      rbdq_pkg::ST_HOLD: begin
        state_next = stat.out_free ? rbdq_pkg::ST_IDLE : rbdq_pkg::ST_HOLD;
      end
      default: state_next = rbdq_pkg::ST_IDLE;
    endcase
  end

  // Drive commands
  always_comb begin
    ctrl.take     = 1'b0;
    ctrl.load_out = 1'b0;
    in_stall      = 1'b1;
    case (state)
      rbdq_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        ctrl.take = in_valid;
      end
      rbdq_pkg::ST_READ,
      rbdq_pkg::ST_HOLD: begin
        ctrl.load_out = stat.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

/* sv/rbdq_datapath.sv */
`default_nettype none
`include "ring_buffer_deque_checker_macros.svh"
module rbdq_datapath (
  input  logic                clk,
  input  logic                rst,
  input  rbdq_pkg::ctrl_t     ctrl,
  output rbdq_pkg::stat_t     stat,
  input  logic [1:0]          command,
  input  logic signed [31:0]  item_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  popped_value,
  output logic                matched,
  output logic [1:0]          status,
  output logic                all_matched
);

  // Element store
  logic [rbdq_pkg::DATA_WIDTH-1:0] mem [rbdq_pkg::DEPTH];
  logic [rbdq_pkg::DATA_WIDTH-1:0] rd_data;

  // Ring state
  rbdq_pkg::idx_t front;
  rbdq_pkg::idx_t back;
  rbdq_pkg::cnt_t count;
  logic           flag;

  // Request in flight
  logic signed [31:0] op_value;
  rbdq_pkg::status_t  op_status;
  logic               op_read;

  // Output register
  logic signed [31:0] out_popped;
  logic               out_matched;
  rbdq_pkg::status_t  out_status;
  logic               out_flag;

  rbdq_pkg::cmd_t     cmd_in;
  logic               is_push;
  logic               full;
  logic               empty;
  logic               wr_en;
  logic               rd_en;
  rbdq_pkg::idx_t     addr;
  rbdq_pkg::idx_t     front_next;
  rbdq_pkg::idx_t     back_next;
  rbdq_pkg::cnt_t     count_next;
  rbdq_pkg::status_t  take_status;
  logic signed [rbdq_pkg::DATA_WIDTH-1:0] wide_val;
  logic signed [rbdq_pkg::DATA_WIDTH-1:0] op_wide;
  logic signed [31:0] res_popped;
  logic               res_ok;

  assign cmd_in   = rbdq_pkg::cmd_t'(command);
  assign is_push  = (cmd_in == rbdq_pkg::CMD_PUSH_FRONT) || (cmd_in == rbdq_pkg::CMD_PUSH_BACK);
  assign full     = (count == rbdq_pkg::CNT_W'(rbdq_pkg::DEPTH));
  assign empty    = (count == '0);
  assign wide_val = rbdq_pkg::DATA_WIDTH'(item_value);
  assign op_wide  = rbdq_pkg::DATA_WIDTH'(op_value);

  // Decode the request: store address, pointer moves and status
  always_comb begin
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    addr        = front;
    front_next  = front;
    back_next   = back;
    count_next  = count;
    take_status = rbdq_pkg::STATUS_DONE;
    if (ctrl.take) begin
      if (is_push && full) begin
        take_status = rbdq_pkg::STATUS_FULL;
      end else if (!is_push && empty) begin
        take_status = rbdq_pkg::STATUS_EMPTY;
      end else begin
        case (cmd_in)
          rbdq_pkg::CMD_PUSH_FRONT: begin
            front_next = rbdq_pkg::idx_dec(front);
            addr       = front_next;
            wr_en      = 1'b1;
            count_next = count + rbdq_pkg::CNT_W'(1);
          end
          rbdq_pkg::CMD_POP_FRONT: begin
            addr       = front;
            front_next = rbdq_pkg::idx_inc(front);
            rd_en      = 1'b1;
            count_next = count - rbdq_pkg::CNT_W'(1);
          end
          rbdq_pkg::CMD_PUSH_BACK: begin
            addr       = back;
            back_next  = rbdq_pkg::idx_inc(back);
            wr_en      = 1'b1;
            count_next = count + rbdq_pkg::CNT_W'(1);
          end
          rbdq_pkg::CMD_POP_BACK: begin
            back_next  = rbdq_pkg::idx_dec(back);
            addr       = back_next;
            rd_en      = 1'b1;
            count_next = count - rbdq_pkg::CNT_W'(1);
          end
          default: begin
            rd_en = 1'b0;
          end
        endcase
      end
    end
  end

  // Write or read the store
  always_ff @(posedge clk) begin
    if (wr_en) mem[addr] <= wide_val;
    if (rd_en) rd_data <= mem[addr];
  end

  // Update ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      back  <= '0;
      count <= '0;
    end else begin
      front <= front_next;
      back  <= back_next;
      count <= count_next;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      op_value  <= item_value;
      op_status <= take_status;
      op_read   <= rd_en;
    end
  end

  // Compare the popped element with the expected one
  always_comb begin
    res_popped = '0;
    res_ok     = 1'b1;
    if (op_read) begin
      res_popped = 32'(signed'(rd_data));
      res_ok     = (rd_data == op_wide);
    end else if (op_status == rbdq_pkg::STATUS_EMPTY) begin
      res_ok = (op_value == '1);
    end
  end

  // Update the sticky flag once per request
  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b1;
    end else if (ctrl.load_out) begin
      flag <= flag & res_ok;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      out_popped  <= res_popped;
      out_matched <= res_ok;
      out_status  <= op_status;
      out_flag    <= flag & res_ok;
    end
  end

  assign stat.out_free = !out_valid || !out_stall;
  assign popped_value  = out_popped;
  assign matched       = out_matched;
  assign status        = out_status;
  assign all_matched   = out_flag;

  `RBDQ_ASSERT_NEVER(a_count_bound, count > rbdq_pkg::CNT_W'(rbdq_pkg::DEPTH), "count over depth")
  `RBDQ_ASSERT(a_push_grows, ctrl.take && is_push && !full |=> count == $past(count) + rbdq_pkg::CNT_W'(1), "push lost")
  `RBDQ_ASSERT(a_no_overwrite, ctrl.load_out |-> stat.out_free, "result overwritten")
  `RBDQ_ASSERT_NEVER(a_flag_revive, !$past(flag) && flag && !$past(rst), "sticky flag set again")

endmodule
`default_nettype wire
